>>> sv/spimbe_pkg.sv
// Package for the SPI master bit engine: command codes, register indexes,
// transaction payload structs and output queue sizing. No dependencies.
package spimbe_pkg;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_END   = 2'd3
   } cmd_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOCK_POLARITY       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SELECT_POLARITY      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MOSI_ON_SECOND_PHASE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MISO_ON_SECOND_PHASE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LSB_FIRST            = 3'd4;

   localparam int unsigned CSR_DATA_WIDTH = 1;

   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned INDEX_WIDTH = $clog2(BYTE_WIDTH);
   localparam logic [INDEX_WIDTH-1:0] LAST_BIT_INDEX = INDEX_WIDTH'(BYTE_WIDTH - 1);

   // Output queue: a start transaction pushes two entries.
   localparam int unsigned OUT_DEPTH       = 4;
   localparam int unsigned OUT_PTR_WIDTH   = $clog2(OUT_DEPTH);
   localparam int unsigned OUT_COUNT_WIDTH = $clog2(OUT_DEPTH + 1);
   localparam int unsigned MAX_PUSH        = 2;

   typedef struct packed {
      cmd_type                cmd;
      logic [BYTE_WIDTH-1:0]  data;
      logic                   data_present;
      logic                   miso_level;
   } req_payload_type;

   typedef struct packed {
      logic                   sclk_level;
      logic                   mosi_level;
      logic                   select_level;
      logic [BYTE_WIDTH-1:0]  read_byte;
      logic                   byte_done;
      logic                   run_last;
   } rsp_payload_type;

endpackage

>>> sv/spi_master_bit_engine.sv
// SPI master bit engine top level: pin-update state machine and result queue.
// Depends on spimbe_pkg.
//
// Usage:
//   req_* carries one command transaction per handshake: start, load byte,
//   half-bit tick or end. rsp_* returns pin updates (clock, MOSI, select),
//   plus the received byte on the update that completes a byte. A start
//   produces two updates, a tick with a byte loaded or an end produces one,
//   a load or an idle tick produces none. run_last marks the final update of
//   each command.
//   Latency: with the queue empty, an update is visible on rsp_* the cycle
//   after its command is accepted. Throughput: one command per cycle while
//   req_ready is high; the result side moves one update per cycle while
//   rsp_ready is high, so back-to-back starts stall. A four-entry queue sets
//   this: req_ready stays high while at least two entries are free, so a
//   stalled receiver holds off new commands once three updates are waiting.
//   csr_* writes the five 1-bit mode registers and takes effect at once.
//   Reset (synchronous): modes cleared, clock low, MOSI low, select high,
//   no byte loaded, queue empty.
module spi_master_bit_engine
   import spimbe_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  req_payload_type             req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rsp_payload_type             rsp_data,
   input  logic                        csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   // mode registers
   logic clock_polarity_ff, select_polarity_ff, mosi_second_ff, miso_second_ff;
   logic lsb_first_ff;

   // engine state
   logic [BYTE_WIDTH-1:0]  send_shift_ff, send_shift_in;
   logic [BYTE_WIDTH-1:0]  recv_byte_ff, recv_byte_in;
   logic [INDEX_WIDTH-1:0] bit_index_ff, bit_index_in;
   logic                   half_phase_ff, half_phase_in;
   logic                   byte_loaded_ff, byte_loaded_in;
   logic                   mosi_ff, mosi_in;
   logic                   sclk_ff, sclk_in;
   logic                   select_ff, select_in;

   // result queue
   rsp_payload_type              queue_ff [OUT_DEPTH];
   logic [OUT_PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [OUT_COUNT_WIDTH-1:0]   count_ff, count_in;

   logic                         req_fire, rsp_fire;
   logic [1:0]                   push_count;
   rsp_payload_type              entry0, entry1;
   logic [INDEX_WIDTH-1:0]       cur_pos;
   logic                         send_bit;
   logic                         first_bit;

   assign req_ready = count_ff <= OUT_COUNT_WIDTH'(OUT_DEPTH - MAX_PUSH);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   // bit position within the byte for the current step (MSB-first counts down)
   assign cur_pos   = lsb_first_ff ? bit_index_ff : ~bit_index_ff;
   assign send_bit  = send_shift_ff[cur_pos];
   assign first_bit = lsb_first_ff ? req_data.data[0] : req_data.data[BYTE_WIDTH-1];

   always_comb begin
      send_shift_in  = send_shift_ff;
      recv_byte_in   = recv_byte_ff;
      bit_index_in   = bit_index_ff;
      half_phase_in  = half_phase_ff;
      byte_loaded_in = byte_loaded_ff;
      mosi_in        = mosi_ff;
      sclk_in        = sclk_ff;
      select_in      = select_ff;
      push_count     = 2'd0;
      entry0         = '0;
      entry1         = '0;

      if (req_fire) begin
         case (req_data.cmd)
            CMD_START: begin
               bit_index_in   = '0;
               half_phase_in  = 1'b0;
               byte_loaded_in = 1'b0;
               mosi_in        = req_data.data_present && first_bit;
               sclk_in        = clock_polarity_ff;
               select_in      = select_polarity_ff;
               entry0.sclk_level   = clock_polarity_ff;
               entry0.mosi_level   = mosi_in;
               entry0.select_level = ~select_polarity_ff;
               entry1.sclk_level   = clock_polarity_ff;
               entry1.mosi_level   = mosi_in;
               entry1.select_level = select_polarity_ff;
               entry1.run_last     = 1'b1;
               push_count          = 2'd2;
            end
            CMD_LOAD: begin
               send_shift_in  = req_data.data;
               recv_byte_in   = '0;
               bit_index_in   = '0;
               half_phase_in  = 1'b0;
               byte_loaded_in = 1'b1;
            end
            CMD_TICK: begin
               if (byte_loaded_ff) begin
                  if (half_phase_ff == mosi_second_ff) begin
                     mosi_in = send_bit;
                  end
                  sclk_in = half_phase_ff ? clock_polarity_ff : ~clock_polarity_ff;
                  if (half_phase_ff == miso_second_ff) begin
                     recv_byte_in[cur_pos] = req_data.miso_level;
                  end
                  entry0.sclk_level   = sclk_in;
                  entry0.mosi_level   = mosi_in;
                  entry0.select_level = select_ff;
                  entry0.run_last     = 1'b1;
                  if (half_phase_ff) begin
                     if (bit_index_ff == LAST_BIT_INDEX) begin
                        entry0.byte_done = 1'b1;
                        entry0.read_byte = recv_byte_in;
                        bit_index_in     = '0;
                        byte_loaded_in   = 1'b0;
                     end else begin
                        bit_index_in = bit_index_ff + 1'b1;
                     end
                     half_phase_in = 1'b0;
                  end else begin
                     half_phase_in = 1'b1;
                  end
                  push_count = 2'd1;
               end
            end
            CMD_END: begin
               select_in      = ~select_polarity_ff;
               bit_index_in   = '0;
               half_phase_in  = 1'b0;
               byte_loaded_in = 1'b0;
               entry0.sclk_level   = sclk_ff;
               entry0.mosi_level   = mosi_ff;
               entry0.select_level = ~select_polarity_ff;
               entry0.run_last     = 1'b1;
               push_count          = 2'd1;
            end
            default: begin
            end
         endcase
      end

      wr_ptr_in = wr_ptr_ff + OUT_PTR_WIDTH'(push_count);
      rd_ptr_in = rd_ptr_ff + OUT_PTR_WIDTH'(rsp_fire);
      count_in  = count_ff + OUT_COUNT_WIDTH'(push_count)
                  - OUT_COUNT_WIDTH'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_polarity_ff  <= 1'b0;
         select_polarity_ff <= 1'b0;
         mosi_second_ff     <= 1'b0;
         miso_second_ff     <= 1'b0;
         lsb_first_ff       <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CLOCK_POLARITY:       clock_polarity_ff  <= csr_wdata[0];
            CSR_SELECT_POLARITY:      select_polarity_ff <= csr_wdata[0];
            CSR_MOSI_ON_SECOND_PHASE: mosi_second_ff     <= csr_wdata[0];
            CSR_MISO_ON_SECOND_PHASE: miso_second_ff     <= csr_wdata[0];
            CSR_LSB_FIRST:            lsb_first_ff       <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_shift_ff  <= '0;
         recv_byte_ff   <= '0;
         bit_index_ff   <= '0;
         half_phase_ff  <= 1'b0;
         byte_loaded_ff <= 1'b0;
         mosi_ff        <= 1'b0;
         sclk_ff        <= 1'b0;
         select_ff      <= 1'b1;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         send_shift_ff  <= send_shift_in;
         recv_byte_ff   <= recv_byte_in;
         bit_index_ff   <= bit_index_in;
         half_phase_ff  <= half_phase_in;
         byte_loaded_ff <= byte_loaded_in;
         mosi_ff        <= mosi_in;
         sclk_ff        <= sclk_in;
         select_ff      <= select_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   // queue storage: payload only, no reset
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= entry0;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= entry1;
      end
   end

endmodule

>>> tb/tb.sv
// Testbench for spi_master_bit_engine: directed and random command streams,
// each pin update checked against a behavioral model of the engine.
// Depends on spimbe_pkg and the spi_master_bit_engine RTL.
module tb
   import spimbe_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_COUNT    = 8;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int DRAIN_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 3;
   localparam int REPORT_LIMIT   = 10;
   localparam int TICKS_PER_BYTE = 2 * BYTE_WIDTH;
   localparam int CSR_INDEX_TOP  = (1 << CSR_INDEX_WIDTH) - 1;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   req_payload_type             req_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   rsp_payload_type             rsp_data;
   logic                        csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata;

   // mode registers as the engine should hold them
   logic cpol, cs_pol, mosi_late, miso_late, lsb_first_mode;
   // engine state
   logic [7:0] tx_shift = '0;
   logic [7:0] rx_byte  = '0;
   logic [2:0] bit_pos  = '0;
   logic       half     = 1'b0;
   logic       loaded   = 1'b0;
   logic       mosi_pin = 1'b0;
   logic       sclk_pin = 1'b0;
   logic       cs_pin   = 1'b1;

   req_payload_type pending_reqs[$];
   rsp_payload_type expected_pins[$];

   logic quiet_mode;
   int   fault_count     = 0;
   int   updates_checked = 0;
   int   bytes_seen      = 0;
   int   req_count       = 0;
   int   stall_cycles    = 0;
   int   planned_items, settings_used;

   spi_master_bit_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] lane_mask(logic [2:0] pos);
      return lsb_first_mode ? (8'h01 << pos) : (8'h80 >> pos);
   endfunction

   function automatic rsp_payload_type pin_update(logic [7:0] rbyte, logic done, logic last);
      rsp_payload_type u;
      u.sclk_level   = sclk_pin;
      u.mosi_level   = mosi_pin;
      u.select_level = cs_pin;
      u.read_byte    = rbyte;
      u.byte_done    = done;
      u.run_last     = last;
      return u;
   endfunction

   // Advance the engine state by one transaction and queue the pin updates it causes.
   task automatic predict_pins(req_payload_type t);
      logic [7:0] m;
      logic       done;
      case (t.cmd)
         CMD_START: begin
            bit_pos  = '0;
            half     = 1'b0;
            loaded   = 1'b0;
            mosi_pin = t.data_present & |(t.data & lane_mask(3'd0));
            sclk_pin = cpol;
            cs_pin   = ~cs_pol;
            expected_pins.push_back(pin_update(8'h00, 1'b0, 1'b0));
            cs_pin   = cs_pol;
            expected_pins.push_back(pin_update(8'h00, 1'b0, 1'b1));
         end
         CMD_LOAD: begin
            tx_shift = t.data;
            rx_byte  = '0;
            bit_pos  = '0;
            half     = 1'b0;
            loaded   = 1'b1;
         end
         CMD_TICK: begin
            if (loaded) begin
               m    = lane_mask(bit_pos);
               done = 1'b0;
               if (half == mosi_late) mosi_pin = |(tx_shift & m);
               sclk_pin = half ? cpol : ~cpol;
               if (half == miso_late) rx_byte = t.miso_level ? (rx_byte | m) : (rx_byte & ~m);
               if (half) begin
                  if (bit_pos == LAST_BIT_INDEX) begin
                     done    = 1'b1;
                     bit_pos = '0;
                     loaded  = 1'b0;
                  end else begin
                     bit_pos = bit_pos + 3'd1;
                  end
               end
               half = ~half;
               expected_pins.push_back(pin_update(done ? rx_byte : 8'h00, done, 1'b1));
            end
         end
         CMD_END: begin
            cs_pin  = ~cs_pol;
            bit_pos = '0;
            half    = 1'b0;
            loaded  = 1'b0;
            expected_pins.push_back(pin_update(8'h00, 1'b0, 1'b1));
         end
         default: ;
      endcase
   endtask

   task automatic write_mode(logic [CSR_INDEX_WIDTH-1:0] idx, logic val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CLOCK_POLARITY:       cpol           = val;
         CSR_SELECT_POLARITY:      cs_pol         = val;
         CSR_MOSI_ON_SECOND_PHASE: mosi_late      = val;
         CSR_MISO_ON_SECOND_PHASE: miso_late      = val;
         CSR_LSB_FIRST:            lsb_first_mode = val;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_pins.size() != 0);
      // a trailing load causes no update, so give it time to land
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_item(cmd_type c, logic [7:0] d, logic p, logic mi, logic counted);
      req_payload_type t;
      t.cmd          = c;
      t.data         = d;
      t.data_present = p;
      t.miso_level   = mi;
      pending_reqs.push_back(t);
      if (counted) planned_items++;
   endtask

   task automatic queue_ticks(int n);
      repeat (n) queue_item(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
   endtask

   task automatic queue_load();
      queue_item(CMD_LOAD, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
   endtask

   task automatic queue_transfer();
      logic present;
      int   nbytes;
      present = $urandom_range(0, 9) != 0;
      nbytes  = present ? $urandom_range(1, 3) : $urandom_range(0, 1);
      queue_item(CMD_START, 8'($urandom), present, 1'($urandom), 1'b1);
      repeat (nbytes) begin
         queue_load();
         queue_ticks(TICKS_PER_BYTE);
         if ($urandom_range(0, 9) == 0)
            queue_item(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
      end
      queue_item(CMD_END, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
   endtask

   // Cut a byte short: end it early or reload in the middle.
   task automatic queue_broken_transfer();
      queue_item(CMD_START, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      queue_load();
      queue_ticks($urandom_range(0, TICKS_PER_BYTE - 1));
      if ($urandom_range(0, 1)) begin
         queue_load();
         queue_ticks(TICKS_PER_BYTE);
      end
      queue_item(CMD_END, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
   endtask

   task automatic queue_noise();
      cmd_type c;
      repeat ($urandom_range(1, 6)) begin
         c = cmd_type'($urandom_range(0, 3));
         queue_item(c, 8'($urandom), 1'($urandom), 1'($urandom), c != CMD_TICK);
      end
   endtask

   task automatic queue_directed();
      queue_item(CMD_START, 8'hFF, 1'b1, 1'b0, 1'b1);
      // no data: MOSI must stay low even though the byte has bits set
      queue_item(CMD_START, 8'hFF, 1'b0, 1'b1, 1'b1);
      queue_item(CMD_LOAD, 8'h81, 1'b0, 1'b0, 1'b1);
      for (int i = 0; i < TICKS_PER_BYTE; i++)
         queue_item(CMD_TICK, 8'h00, 1'b0, i < BYTE_WIDTH, 1'b1);
      // byte finished, so this tick drops out
      queue_item(CMD_TICK, 8'hFF, 1'b1, 1'b1, 1'b0);
      queue_item(CMD_END, 8'h00, 1'b0, 1'b0, 1'b1);
      queue_item(CMD_LOAD, 8'h00, 1'b1, 1'b1, 1'b1);
      queue_item(CMD_TICK, 8'h00, 1'b0, 1'b1, 1'b1);
      queue_item(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b1);
      queue_item(CMD_END, 8'hFF, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic queue_random(int budget);
      int target;
      int pick;
      target = planned_items + budget;
      while (planned_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)      queue_transfer();
         else if (pick < 90) queue_broken_transfer();
         else                queue_noise();
      end
   endtask

   // Sender: hold each transaction until accepted, idle at random otherwise.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() != 0 && (quiet_mode || $urandom_range(0, 99) >= 9)) begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= quiet_mode || $urandom_range(0, 99) >= 9;
      end
   end

   always @(posedge clock) begin : check_pins
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_pins(req_data);
            req_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pins.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: pin update with none pending: %p", $time, rsp_data);
            end else begin
               want = expected_pins.pop_front();
               updates_checked++;
               if (want.byte_done) bytes_seen++;
               if (rsp_data.sclk_level   !== want.sclk_level   ||
                   rsp_data.mosi_level   !== want.mosi_level   ||
                   rsp_data.select_level !== want.select_level ||
                   rsp_data.read_byte    !== want.read_byte    ||
                   rsp_data.byte_done    !== want.byte_done    ||
                   rsp_data.run_last     !== want.run_last) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("%0t: pin update mismatch: want %p got %p",
                              $time, want, rsp_data);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, stall_cycles);
         $display("tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic mode_bit;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      quiet_mode     = 1'b0;
      cpol           = 1'b0;
      cs_pol         = 1'b0;
      mosi_late      = 1'b0;
      miso_late      = 1'b0;
      lsb_first_mode = 1'b0;
      planned_items  = 0;
      settings_used  = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_idle();
         quiet_mode = (ph == 3);
         // all-low and all-high first, then mixed settings
         for (int r = 0; r <= CSR_INDEX_TOP; r++) begin
            if (ph == 0)      mode_bit = 1'b0;
            else if (ph == 1) mode_bit = 1'b1;
            else              mode_bit = 1'($urandom);
            write_mode(CSR_INDEX_WIDTH'(r), mode_bit);
         end
         @(posedge clock);
         csr_wr_en <= 1'b0;
         settings_used++;

         if (ph == 0) queue_directed();
         // pick up a byte left half-shifted under the previous setting
         else queue_ticks($urandom_range(0, 8));
         queue_random(RANDOM_ITEMS / PHASE_COUNT);
         if (ph < PHASE_COUNT - 1) begin
            queue_load();
            queue_ticks($urandom_range(1, TICKS_PER_BYTE - 1));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d transactions over %0d mode settings", req_count, settings_used);
      $display("tb: %0d pin updates compared, %0d bytes received, %0d faults",
               updates_checked, bytes_seen, fault_count);
      if (fault_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

>>> spi_master_bit_engine.f
sv/spimbe_pkg.sv
sv/spi_master_bit_engine.sv
tb/tb.sv
